>>> rtl/periodic_timer_drift_monitor_defines.svh
// ----------------------------------------------------------------------------
// periodic timer drift monitor assertion macros
// shared property wrappers, all sampled on the rising clock edge and
// disabled while the synchronous active-low reset is held
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TIMER_DRIFT_MONITOR_DEFINES_SVH
`define PERIODIC_TIMER_DRIFT_MONITOR_DEFINES_SVH

// same-cycle implication
`define PTDM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ptdm assertion failed");

// next-cycle implication
`define PTDM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ptdm assertion failed");

`endif

>>> rtl/ptdm_pkg.sv
// ----------------------------------------------------------------------------
// ptdm_pkg
// widths, constants, controller states and command/status types shared by
// the periodic timer drift monitor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ptdm_pkg;

    localparam int TS_W        = 52;
    localparam int RES_W       = 32;
    localparam int SUM_W       = 64;
    localparam int PERIOD_W    = 16;
    localparam int PERIOD_US_W = 26;
    localparam int DIVISOR_W   = RES_W + 1;
    localparam int DIV_STEPS   = 32;
    localparam int DIV_CNT_W   = 5;
    localparam int IN_TDATA_W  = 160;
    localparam int OUT_TDATA_W = 288;

    localparam logic [PERIOD_W-1:0]    PERIOD_RESET = 16'd1000;
    localparam logic [PERIOD_US_W-1:0] US_PER_MS    = 26'd1000;
    localparam logic [RES_W-1:0]       MIN_START    = 32'd10000;
    localparam logic [RES_W-1:0]       U32_MAX      = 32'hFFFF_FFFF;
    localparam logic [RES_W-1:0]       S32_MAX      = 32'h7FFF_FFFF;
    localparam logic [RES_W-1:0]       S32_MIN      = 32'h8000_0000;
    localparam logic [SUM_W-1:0]       U64_MAX      = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_DRIFT,
        ST_ABS,
        ST_UPDATE,
        ST_DIV_GO,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load_in;
        logic diff;
        logic drift;
        logic absv;
        logic update;
        logic div_start;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
    } t_dp_status;

endpackage

`default_nettype wire

>>> rtl/periodic_timer_drift_monitor.sv
// ----------------------------------------------------------------------------
// periodic_timer_drift_monitor
// per-firing drift, compensated sleep and running drift/add-time statistics
// ----------------------------------------------------------------------------
// One input beat is one timer firing; one output beat follows for each. An
// accepted firing goes through four arithmetic stages and a divider start,
// then two 32-step restoring dividers running side by side for the two
// averages. The controller then sees the dividers finish and loads the
// output register, waiting while the previous beat is still held there and
// not taken. The input is ready again once the result has been loaded, so
// the block takes no new firing before it is through with the last one.
// The next firing is taken as soon as its
// predecessor's result sits in the output register, even if that beat has
// not yet been taken downstream. The period register can be written at any
// time on the config channel (ready is always high) and is sampled when a
// firing is accepted.
`timescale 1ns / 1ps
`default_nettype none

module periodic_timer_drift_monitor
    import ptdm_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // config channel: period_ms
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [PERIOD_W-1:0]    i_cfg_data,
    // input stream
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // add_start_us[51:0], enqueue_us[103:52], add_end_us[155:104], zero pad
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // output stream
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    // drift_us, next_sleep_us, avg_drift_us, max_drift_us, min_drift_us,
    // add_time_us, avg_add_time_us, max_add_time_us, min_add_time_us (32 each)
    output logic [OUT_TDATA_W-1:0]      o_m_axis_tdata,
    // stats_valid
    output logic                        o_m_axis_tuser
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    assign o_cfg_ready = 1'b1;

    ptdm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    ptdm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_tdata     (i_s_axis_tdata),
        .o_tdata     (o_m_axis_tdata),
        .o_tuser     (o_m_axis_tuser)
    );

endmodule

`default_nettype wire

>>> rtl/ptdm_div.sv
// ----------------------------------------------------------------------------
// ptdm_div
// restoring divider, one quotient bit per cycle, quotient saturated to
// 32 bits (saturation is detected up front from the upper dividend half)
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptdm_div
    import ptdm_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [SUM_W-1:0]     i_dividend,
    input  wire logic [DIVISOR_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [RES_W-1:0]          o_quot
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_sat;
    logic [DIVISOR_W-1:0] r_rem;
    logic [RES_W-1:0]     r_low;
    logic [DIVISOR_W-1:0] r_divisor;

    logic [DIVISOR_W:0]   w_trial;
    logic                 w_fit;
    logic [DIVISOR_W:0]   w_diff;

    assign w_trial = {r_rem, r_low[RES_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_divisor});
    assign w_diff  = w_trial - {1'b0, r_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_STEPS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            // quotient needs more than 32 bits when the upper half already fits
            r_sat     <= ({1'b0, i_dividend[SUM_W-1:RES_W]} >= i_divisor);
            r_rem     <= {1'b0, i_dividend[SUM_W-1:RES_W]};
            r_low     <= i_dividend[RES_W-1:0];
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_fit ? w_diff[DIVISOR_W-1:0] : w_trial[DIVISOR_W-1:0];
            r_low <= {r_low[RES_W-2:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_sat ? U32_MAX : r_low;

endmodule

`default_nettype wire

>>> rtl/ptdm_dp.sv
// ----------------------------------------------------------------------------
// ptdm_dp
// datapath: period register, timestamp arithmetic, running statistics,
// two dividers for the averages and the result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptdm_dp
    import ptdm_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_valid,
    input  wire logic [PERIOD_W-1:0]    i_cfg_data,
    input  wire t_dp_cmd                i_cmd,
    output t_dp_status                  o_status,
    input  wire logic [IN_TDATA_W-1:0]  i_tdata,
    output logic [OUT_TDATA_W-1:0]      o_tdata,
    output logic                        o_tuser
);

    // configuration and persistent state
    logic [PERIOD_W-1:0]    r_period_ms;
    logic [RES_W-1:0]       r_count;
    logic [TS_W-1:0]        r_prev_enq;
    logic [RES_W-1:0]       r_sleep;
    logic [SUM_W-1:0]       r_drift_sum;
    logic [SUM_W-1:0]       r_add_sum;
    logic [RES_W-1:0]       r_drift_max;
    logic [RES_W-1:0]       r_drift_min;
    logic [RES_W-1:0]       r_add_max;
    logic [RES_W-1:0]       r_add_min;

    // per-item working registers
    logic [TS_W-1:0]        r_start;
    logic [TS_W-1:0]        r_enq;
    logic [TS_W-1:0]        r_end;
    logic [PERIOD_US_W-1:0] r_period_us;
    logic                   r_first;
    logic [RES_W-1:0]       r_add_time;
    logic [TS_W:0]          r_elapsed;
    logic [TS_W+1:0]        r_drift;
    logic [RES_W-1:0]       r_abs32;
    logic [RES_W-1:0]       r_drift_out;
    logic [RES_W-1:0]       r_ns32;
    logic [DIVISOR_W-1:0]   r_div_intervals;
    logic [DIVISOR_W-1:0]   r_div_firings;

    // result register
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic                   r_out_user;

    logic [TS_W:0]          w_add_diff;
    logic [TS_W+1:0]        w_mag;
    logic [TS_W+3:0]        w_ns;
    logic [SUM_W:0]         w_drift_sum;
    logic [SUM_W:0]         w_add_sum;
    logic                   w_drift_done;
    logic                   w_add_done;
    logic [RES_W-1:0]       w_q_drift;
    logic [RES_W-1:0]       w_q_add;

    assign w_add_diff  = {1'b0, r_end} - {1'b0, r_start};
    assign w_mag       = r_drift[TS_W+1] ? (~r_drift + 1'b1) : r_drift;
    assign w_ns        = {24'd0, r_sleep} - {{2{r_drift[TS_W+1]}}, r_drift};
    assign w_drift_sum = {1'b0, r_drift_sum} + {33'd0, r_abs32};
    assign w_add_sum   = {1'b0, r_add_sum} + {33'd0, r_add_time};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period_ms <= PERIOD_RESET;
            r_count     <= '0;
            r_prev_enq  <= '0;
            r_sleep     <= '0;
            r_drift_sum <= '0;
            r_add_sum   <= '0;
            r_drift_max <= '0;
            r_drift_min <= MIN_START;
            r_add_max   <= '0;
            r_add_min   <= MIN_START;
        end else begin
            if (i_cfg_valid) begin
                r_period_ms <= i_cfg_data;
            end
            if (i_cmd.update) begin
                r_add_sum  <= w_add_sum[SUM_W] ? U64_MAX : w_add_sum[SUM_W-1:0];
                r_prev_enq <= r_enq;
                if (r_count != U32_MAX) begin
                    r_count <= r_count + 1'b1;
                end
                if (r_first) begin
                    r_sleep <= RES_W'(r_period_us);
                end else begin
                    r_sleep     <= r_ns32;
                    r_drift_sum <= w_drift_sum[SUM_W] ? U64_MAX : w_drift_sum[SUM_W-1:0];
                    if (r_abs32 > r_drift_max) begin
                        r_drift_max <= r_abs32;
                    end
                    if (r_abs32 < r_drift_min) begin
                        r_drift_min <= r_abs32;
                    end
                    if (r_add_time > r_add_max) begin
                        r_add_max <= r_add_time;
                    end
                    if (r_add_time < r_add_min) begin
                        r_add_min <= r_add_time;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_start     <= i_tdata[TS_W-1:0];
            r_enq       <= i_tdata[2*TS_W-1:TS_W];
            r_end       <= i_tdata[3*TS_W-1:2*TS_W];
            r_period_us <= PERIOD_US_W'(r_period_ms) * US_PER_MS;
        end
        if (i_cmd.diff) begin
            r_first   <= (r_count == '0);
            r_elapsed <= {1'b0, r_enq} - {1'b0, r_prev_enq};
            if (w_add_diff[TS_W]) begin
                r_add_time <= '0;
            end else if (|w_add_diff[TS_W-1:RES_W]) begin
                r_add_time <= U32_MAX;
            end else begin
                r_add_time <= w_add_diff[RES_W-1:0];
            end
        end
        if (i_cmd.drift) begin
            r_drift <= {r_elapsed[TS_W], r_elapsed} - {28'd0, r_period_us};
        end
        if (i_cmd.absv) begin
            r_abs32 <= (|w_mag[TS_W+1:RES_W]) ? U32_MAX : w_mag[RES_W-1:0];
            // signed saturation to 32 bits
            if (!r_drift[TS_W+1] && (|r_drift[TS_W:RES_W-1])) begin
                r_drift_out <= S32_MAX;
            end else if (r_drift[TS_W+1] && !(&r_drift[TS_W:RES_W-1])) begin
                r_drift_out <= S32_MIN;
            end else begin
                r_drift_out <= r_drift[RES_W-1:0];
            end
            if (w_ns[TS_W+3]) begin
                r_ns32 <= '0;
            end else if (|w_ns[TS_W+2:RES_W]) begin
                r_ns32 <= U32_MAX;
            end else begin
                r_ns32 <= w_ns[RES_W-1:0];
            end
        end
        if (i_cmd.update) begin
            r_div_intervals <= {1'b0, r_count};
            r_div_firings   <= {1'b0, r_count} + 1'b1;
        end
        if (i_cmd.load_out) begin
            r_out_data <= {r_add_min,
                           r_add_max,
                           w_q_add,
                           r_add_time,
                           r_drift_min,
                           r_drift_max,
                           r_first ? '0 : w_q_drift,
                           r_sleep,
                           r_first ? '0 : r_drift_out};
            r_out_user <= !r_first;
        end
    end

    ptdm_div u_div_drift (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_drift_sum),
        .i_divisor  (r_div_intervals),
        .o_done     (w_drift_done),
        .o_quot     (w_q_drift)
    );

    ptdm_div u_div_add (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_add_sum),
        .i_divisor  (r_div_firings),
        .o_done     (w_add_done),
        .o_quot     (w_q_add)
    );

    assign o_status.div_done = w_drift_done & w_add_done;
    assign o_tdata           = r_out_data;
    assign o_tuser           = r_out_user;

endmodule

`default_nettype wire

>>> rtl/ptdm_ctrl.sv
// ----------------------------------------------------------------------------
// ptdm_ctrl
// sequencer for one firing: arithmetic stages, divider run and hand-off to
// the result register, which frees the input side while a beat waits
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "periodic_timer_drift_monitor_defines.svh"

module ptdm_ctrl
    import ptdm_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_dp_cmd         o_cmd,
    input  wire t_dp_status i_status
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
                if (i_in_valid) begin
                    n_state = ST_DIFF;
                end
            end
            ST_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state    = ST_DRIFT;
            end
            ST_DRIFT: begin
                o_cmd.drift = 1'b1;
                n_state     = ST_ABS;
            end
            ST_ABS: begin
                o_cmd.absv = 1'b1;
                n_state    = ST_UPDATE;
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = ST_DIV_GO;
            end
            ST_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIV;
            end
            ST_DIV: begin
                if (i_status.div_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                // result register free or emptied this cycle
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

    `PTDM_ASSERT_SAME(a_no_overwrite, i_clk, i_rst_n, o_cmd.load_out, !r_out_valid || i_out_ready)
    `PTDM_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state == ST_DIFF)
    `PTDM_ASSERT_SAME(a_done_in_wait, i_clk, i_rst_n, i_status.div_done, r_state == ST_DIV)
    `PTDM_ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, o_cmd.load_out, r_out_valid)

endmodule

`default_nettype wire
